>>> rtl/core/mrpt_pkg.sv
// shared types, constants and codes for the memory region policy table
// no dependencies; imported by every module of the block

package mrpt_pkg;

  // table geometry
  localparam int REGIONS   = 64;
  localparam int ADDR_BITS = 48;
  localparam int IDX_W     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int CTX_W     = 8;
  localparam int POL_W     = 3;
  localparam int END_W     = ADDR_BITS + 1;

  // access kinds
  localparam logic [2:0] KIND_ATOMIC     = 3'd0;
  localparam logic [2:0] KIND_FLUSH      = 3'd1;
  localparam logic [2:0] KIND_LOCKED_RMW = 3'd2;
  localparam logic [2:0] KIND_IFETCH     = 3'd3;
  localparam logic [2:0] KIND_READ       = 3'd4;
  localparam logic [2:0] KIND_WRITE      = 3'd5;

  // policy codes
  localparam logic [POL_W-1:0] POL_DEFAULT = 3'd0;
  localparam logic [POL_W-1:0] POL_WT      = 3'd1;
  localparam logic [POL_W-1:0] POL_LG      = 3'd2;
  localparam logic [POL_W-1:0] POL_LGO     = 3'd3;
  localparam logic [POL_W-1:0] POL_SLGO    = 3'd4;

  // request types
  localparam logic [3:0] REQ_ATOMIC  = 4'd0;
  localparam logic [3:0] REQ_FLUSH   = 4'd1;
  localparam logic [3:0] REQ_ST      = 4'd2;
  localparam logic [3:0] REQ_IFETCH  = 4'd3;
  localparam logic [3:0] REQ_LD_LG   = 4'd4;
  localparam logic [3:0] REQ_LD_LGO  = 4'd5;
  localparam logic [3:0] REQ_LD_SLGO = 4'd6;
  localparam logic [3:0] REQ_LD      = 4'd7;
  localparam logic [3:0] REQ_ST_WT   = 4'd8;
  localparam logic [3:0] REQ_ST_LGO  = 4'd9;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_READ   = 3'd1;
  localparam logic [2:0] ST_BAD_WRITE  = 3'd2;
  localparam logic [2:0] ST_BAD_KIND   = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;

  // item modes
  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  // register index (byte address bit 2)
  localparam logic REG_X86_MODE   = 1'b0;
  localparam logic REG_SHARED_CTX = 1'b1;

  typedef struct packed {
    logic [POL_W-1:0] rmw;
    logic [POL_W-1:0] wr;
    logic [POL_W-1:0] rd;
  } pol_t;

  typedef struct packed {
    logic             store_check;
    logic [2:0]       access_kind;
    logic [POL_W-1:0] rmw_pol;
    logic [POL_W-1:0] write_pol;
    logic [POL_W-1:0] read_pol;
    logic [CTX_W-1:0] context_req;
    logic [ADDR_BITS-1:0] region_length;
    logic [ADDR_BITS-1:0] address;
  } item_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;

  typedef struct packed {
    logic [2:0]       status;
    logic [POL_W-1:0] eff_rmw_pol;
    logic [POL_W-1:0] eff_write_pol;
    logic [POL_W-1:0] eff_read_pol;
    logic [3:0]       request_type;
  } result_t;

  localparam int M_DATA_W = $bits(result_t);

  typedef struct packed {
    pol_t                 pol;
    logic [END_W-1:0]     region_end;
    logic [ADDR_BITS-1:0] start;
    logic [CTX_W-1:0]     ctx;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/mrpt_regs.sv
// configuration registers behind the apb-style port
// depends on mrpt_pkg

module mrpt_regs
  import mrpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             x86_mode,
  output logic [CTX_W-1:0] shared_context
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x86_mode       <= 1'b0;
      shared_context <= '1;
    end else if (wr_en) begin
      if (paddr[2] == REG_X86_MODE) begin
        x86_mode <= pwdata[0];
      end else begin
        shared_context <= pwdata[CTX_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SHARED_CTX) begin
      prdata = {{(32-CTX_W){1'b0}}, shared_context};
    end else begin
      prdata = {31'b0, x86_mode};
    end
  end

endmodule

>>> rtl/core/mrpt_ctrl.sv
// sequencer for the table scan: accept, scan, drain, finish
// depends on mrpt_pkg

module mrpt_ctrl
  import mrpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        state_next = FINISH;
      end
      FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == IDLE);
    end
  end

endmodule

>>> rtl/core/mrpt_datapath.sv
// region store, scan trackers, policy resolution and output register
// depends on mrpt_pkg

module mrpt_datapath
  import mrpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             item_mode,
  input  item_t            item,
  input  logic             x86_mode,
  input  logic [CTX_W-1:0] shared_context,
  output logic             m_tvalid,
  input  logic             m_tready,
  output result_t          m_res
);

  entry_t mem [REGIONS];
  logic [REGIONS-1:0] valid;

  logic     cur_mode;
  item_t    cur;
  logic [IDX_W-1:0] cnt;
  logic     rd_vld;
  logic [IDX_W-1:0] rd_idx;
  entry_t   rd_entry;

  // best-match trackers for own and shared context
  logic                 own_found, sh_found;
  logic [ADDR_BITS-1:0] own_start, sh_start;
  logic [END_W-1:0]     own_end, sh_end;
  pol_t                 own_pol, sh_pol;

  // insert slot trackers
  logic             match_found, free_found;
  logic [IDX_W-1:0] match_slot, free_slot;

  logic rd_live, own_cand, sh_cand, same_key, is_free;
  logic ins_ok;
  logic [IDX_W-1:0] ins_slot;
  entry_t  new_entry;
  pol_t    own_eff, sh_eff, eff;
  result_t res;

  assign stat.scan_last = (cnt == IDX_W'(REGIONS - 1));
  assign stat.out_free  = !m_tvalid || m_tready;

  // evaluation of the entry read in the previous cycle
  assign rd_live  = rd_vld && valid[rd_idx];
  assign is_free  = rd_vld && !valid[rd_idx];
  assign same_key = rd_live && (rd_entry.ctx == cur.context_req)
                    && (rd_entry.start == cur.address);
  assign own_cand = rd_live && (rd_entry.ctx == cur.context_req)
                    && (rd_entry.start <= cur.address)
                    && (!own_found || (rd_entry.start > own_start));
  assign sh_cand  = rd_live && (rd_entry.ctx == shared_context)
                    && (rd_entry.start <= cur.address)
                    && (!sh_found || (rd_entry.start > sh_start));

  assign ins_ok   = match_found || free_found;
  assign ins_slot = match_found ? match_slot : free_slot;

  always_comb begin
    new_entry.ctx        = cur.context_req;
    new_entry.start      = cur.address;
    new_entry.region_end = {1'b0, cur.address} + {1'b0, cur.region_length};
    new_entry.pol.rd     = cur.read_pol;
    new_entry.pol.wr     = cur.write_pol;
    new_entry.pol.rmw    = cur.rmw_pol;
  end

  // hit check on the chosen regions, then fallback per policy
  always_comb begin
    own_eff = (own_found && ({1'b0, cur.address} < own_end)) ? own_pol : '0;
    sh_eff  = (sh_found && ({1'b0, cur.address} < sh_end)) ? sh_pol : '0;
    eff.rd  = (own_eff.rd  == POL_DEFAULT) ? sh_eff.rd  : own_eff.rd;
    eff.wr  = (own_eff.wr  == POL_DEFAULT) ? sh_eff.wr  : own_eff.wr;
    eff.rmw = (own_eff.rmw == POL_DEFAULT) ? sh_eff.rmw : own_eff.rmw;
  end

  always_comb begin
    res = '0;
    if (cur_mode == MODE_INSERT) begin
      res.status = ins_ok ? ST_OK : ST_TABLE_FULL;
    end else begin
      res.eff_read_pol  = eff.rd;
      res.eff_write_pol = eff.wr;
      res.eff_rmw_pol   = eff.rmw;
      case (cur.access_kind)
        KIND_ATOMIC:     res.request_type = REQ_ATOMIC;
        KIND_FLUSH:      res.request_type = REQ_FLUSH;
        KIND_LOCKED_RMW: res.request_type = REQ_ST;
        KIND_IFETCH:     res.request_type = REQ_IFETCH;
        KIND_READ: begin
          if (x86_mode && cur.store_check) begin
            res.request_type = REQ_ST;
          end else begin
            case (eff.rd)
              POL_LG:      res.request_type = REQ_LD_LG;
              POL_LGO:     res.request_type = REQ_LD_LGO;
              POL_SLGO:    res.request_type = REQ_LD_SLGO;
              POL_DEFAULT: res.request_type = REQ_LD;
              default:     res.status       = ST_BAD_READ;
            endcase
          end
        end
        KIND_WRITE: begin
          case (eff.wr)
            POL_WT:      res.request_type = REQ_ST_WT;
            POL_LGO:     res.request_type = REQ_ST_LGO;
            POL_DEFAULT: res.request_type = REQ_ST;
            default:     res.status       = ST_BAD_WRITE;
          endcase
        end
        default: res.status = ST_BAD_KIND;
      endcase
    end
  end

  // region store: one read per scan cycle, one write at finish
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_entry <= mem[cnt];
    end
    if (cmd.finish && (cur_mode == MODE_INSERT) && ins_ok) begin
      mem[ins_slot] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= cmd.step;
      if (cmd.finish && (cur_mode == MODE_INSERT) && ins_ok) begin
        valid[ins_slot] <= 1'b1;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_mode    <= item_mode;
      cur         <= item;
      cnt         <= '0;
      own_found   <= 1'b0;
      sh_found    <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (cmd.step) begin
        cnt    <= cnt + 1'b1;
        rd_idx <= cnt;
      end
      if (own_cand) begin
        own_found <= 1'b1;
        own_start <= rd_entry.start;
        own_end   <= rd_entry.region_end;
        own_pol   <= rd_entry.pol;
      end
      if (sh_cand) begin
        sh_found <= 1'b1;
        sh_start <= rd_entry.start;
        sh_end   <= rd_entry.region_end;
        sh_pol   <= rd_entry.pol;
      end
      if (same_key && !match_found) begin
        match_found <= 1'b1;
        match_slot  <= rd_idx;
      end
      if (is_free && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx;
      end
    end
    if (cmd.finish) begin
      m_res <= res;
    end
  end

endmodule

>>> rtl/core/memory_region_policy_table_unit.sv
// memory region policy table: top level with stream ports and register port
// depends on mrpt_pkg, mrpt_regs, mrpt_ctrl, mrpt_datapath
// per item: a scan of all 64 entries, then drain, then finish; finish waits until the result register is free
// one item at a time: no new item is taken until the last one finishes, set by the single read port
//   of the region store being swept once per item, one entry a cycle
// reset: rst synchronous, active high; clears all valid bits at once, x86_mode to 0
//   and shared_context to 255; no clearing pass is needed

module memory_region_policy_table_unit
  import mrpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // address, region_length, context_req, read_pol, write_pol, rmw_pol,
  // access_kind, store_check, zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  // mode
  input  logic                s_tuser,
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  // request_type, eff_read_pol, eff_write_pol, eff_rmw_pol, status
  output logic [M_DATA_W-1:0] m_tdata
);

  logic             x86_mode;
  logic [CTX_W-1:0] shared_context;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  item_t            item;
  result_t          m_res;

  // unpack the transfer; pad bits above the item are ignored
  assign item    = item_t'(s_tdata[ITEM_W-1:0]);
  assign m_tdata = m_res;

  // configuration; the user must write it only while the block is idle, the block itself does not enforce this
  mrpt_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .x86_mode       (x86_mode),
    .shared_context (shared_context)
  );

  // sequencer: one item at a time, sweeps every entry once
  mrpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // region store and per-entry evaluation; the output register lets the next
  // item be taken while a result still waits downstream
  mrpt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .item_mode      (s_tuser),
    .item           (item),
    .x86_mode       (x86_mode),
    .shared_context (shared_context),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_res          (m_res)
  );

endmodule
